// File: src/czc_pkg.sv
// ----------------------------------------------------------------------------
// czc_pkg
// Types and fixed constants shared by the cymbal zone and choke detector.
// ----------------------------------------------------------------------------
package czc_pkg;

   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int HOLD_W     = 16;
   localparam int TIME_W     = 32;
   localparam int CMP_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CMP_W-1:0] CHOKE_LEVEL = 16'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_PAD_NOTE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_NOTE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHOKE_HOLD   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHOKE_ENABLE = 2'd3;

   localparam logic EVENT_NOTE       = 1'b0;
   localparam logic EVENT_AFTERTOUCH = 1'b1;

   typedef struct packed {
      logic              event_kind;
      logic [NOTE_W-1:0] note_number;
      logic [VEL_W-1:0]  event_velocity;
      logic              last_of_run;
   } event_type;

   // Words produced by one accepted item, first word in ev0.
   typedef struct packed {
      logic [1:0] count;
      event_type  ev0;
      event_type  ev1;
   } push_type;

endpackage

// File: src/czc_ifaces.sv
// ----------------------------------------------------------------------------
// czc_ifaces
// Valid/ready channel interfaces for sample items and result events.
// ----------------------------------------------------------------------------
interface czc_req_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                         valid;
   logic                         ready;
   logic [SAMPLE_BITS-1:0]       zone_sample;
   logic [czc_pkg::VEL_W-1:0]    hit_velocity;
   logic                         reader_scanning;
   logic [czc_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, zone_sample, hit_velocity, reader_scanning, now_ms,
                   input ready);
   modport sink   (input valid, zone_sample, hit_velocity, reader_scanning, now_ms,
                   output ready);
endinterface

interface czc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         event_kind;
   logic [czc_pkg::NOTE_W-1:0]   note_number;
   logic [czc_pkg::VEL_W-1:0]    event_velocity;
   logic                         last_of_run;

   modport source (output valid, event_kind, note_number, event_velocity, last_of_run,
                   input ready);
   modport sink   (input valid, event_kind, note_number, event_velocity, last_of_run,
                   output ready);
endinterface

// File: src/czc_core.sv
// ----------------------------------------------------------------------------
// czc_core
// Control registers, zone minimum and choke state; builds the events of one
// accepted sample word.
// ----------------------------------------------------------------------------
module czc_core #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [czc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [czc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              accept,
   input  logic [SAMPLE_BITS-1:0]            zone_sample,
   input  logic [czc_pkg::VEL_W-1:0]         hit_velocity,
   input  logic                              reader_scanning,
   input  logic [czc_pkg::TIME_W-1:0]        now_ms,
   output czc_pkg::push_type                 push
);

   localparam logic [SAMPLE_BITS-1:0] ZONE_FULL = {SAMPLE_BITS{1'b1}};

   logic [czc_pkg::NOTE_W-1:0] pad_note_ff, edge_note_ff;
   logic [czc_pkg::HOLD_W-1:0] hold_ff;
   logic                       enable_ff;

   logic [SAMPLE_BITS-1:0]     min_ff, min_in, min_upd;
   logic                       active_ff, active_in;
   logic                       reported_ff, reported_in;
   logic [czc_pkg::TIME_W-1:0] start_ff, start_in;

   logic                       hit, in_area, choke_fire;
   logic [czc_pkg::TIME_W-1:0] held;
   czc_pkg::event_type         note_ev, touch_ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_note_ff  <= '0;
         edge_note_ff <= '0;
         hold_ff      <= '0;
         enable_ff    <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            czc_pkg::CSR_PAD_NOTE:     pad_note_ff  <= csr_wdata[czc_pkg::NOTE_W-1:0];
            czc_pkg::CSR_EDGE_NOTE:    edge_note_ff <= csr_wdata[czc_pkg::NOTE_W-1:0];
            czc_pkg::CSR_CHOKE_HOLD:   hold_ff      <= csr_wdata[czc_pkg::HOLD_W-1:0];
            czc_pkg::CSR_CHOKE_ENABLE: enable_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      min_upd = (reader_scanning && (zone_sample < min_ff)) ? zone_sample : min_ff;
      hit     = (hit_velocity != '0);
      min_in  = hit ? ZONE_FULL : min_upd;

      in_area     = (czc_pkg::CMP_W'(zone_sample) <= czc_pkg::CHOKE_LEVEL);
      active_in   = active_ff;
      reported_in = reported_ff;
      start_in    = start_ff;
      if (enable_ff) begin
         if (active_ff && !in_area) begin
            active_in   = 1'b0;
            reported_in = 1'b0;
         end else if (!active_ff && in_area) begin
            start_in  = now_ms;
            active_in = 1'b1;
         end
      end
      held       = now_ms - start_in;
      choke_fire = enable_ff && active_in && !reported_in &&
                   (held >= czc_pkg::TIME_W'(hold_ff));
      if (choke_fire) begin
         reported_in = 1'b1;
      end

      note_ev.event_kind     = czc_pkg::EVENT_NOTE;
      note_ev.note_number    = (czc_pkg::CMP_W'(min_upd) > czc_pkg::CHOKE_LEVEL) ?
                               pad_note_ff : edge_note_ff;
      note_ev.event_velocity = hit_velocity;
      note_ev.last_of_run    = !choke_fire;

      touch_ev.event_kind     = czc_pkg::EVENT_AFTERTOUCH;
      touch_ev.note_number    = edge_note_ff;
      touch_ev.event_velocity = '0;
      touch_ev.last_of_run    = 1'b1;

      push.count = '0;
      push.ev0   = note_ev;
      push.ev1   = touch_ev;
      if (accept) begin
         push.count = {hit && choke_fire, hit != choke_fire};
         if (!hit) begin
            push.ev0 = touch_ev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= ZONE_FULL;
         active_ff   <= 1'b0;
         reported_ff <= 1'b0;
         start_ff    <= '0;
      end else if (accept) begin
         min_ff      <= min_in;
         active_ff   <= active_in;
         reported_ff <= reported_in;
         start_ff    <= start_in;
      end
   end

endmodule

// File: src/czc_evq.sv
// ----------------------------------------------------------------------------
// czc_evq
// Four-entry result queue: takes up to two event words a cycle while two slots are free, hands out one.
// ----------------------------------------------------------------------------
module czc_evq (
   input  logic               clock,
   input  logic               reset,
   input  czc_pkg::push_type  push,
   output logic               room,
   czc_rsp_if.source          rsp_bus
);

   czc_pkg::event_type entry_ff [4];
   logic [1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [2:0]         count_ff, count_in;
   logic               pop;
   czc_pkg::event_type head_ev;

   // Hold off input unless two slots are free.
   assign room = (count_ff <= 3'd2);
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      head_in  = head_ff + {1'b0, pop};
      tail_in  = tail_ff + push.count;
      count_in = count_ff + {1'b0, push.count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail_ff] <= push.ev0;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_ff + 2'd1] <= push.ev1;
      end
   end

   assign head_ev                = entry_ff[head_ff];
   assign rsp_bus.valid          = (count_ff != 3'd0);
   assign rsp_bus.event_kind     = head_ev.event_kind;
   assign rsp_bus.note_number    = head_ev.note_number;
   assign rsp_bus.event_velocity = head_ev.event_velocity;
   assign rsp_bus.last_of_run    = head_ev.last_of_run;

endmodule

// File: src/cymbal_zone_and_choke_detector_top.sv
// ----------------------------------------------------------------------------
// cymbal_zone_and_choke_detector_top
// Tracks the zone minimum while the piezo reader scans, picks pad or edge note
// on a hit and, with choke enabled, reports one choke aftertouch per held edge press.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          contents
//  req_bus   in         valid/ready        zone sample, velocity, scan flag, ms time
//  rsp_bus   out        valid/ready        event kind, note, velocity, last flag
//  csr_*     in         write enable only  pad/edge note, choke hold, choke enable
//
//  One sample word is taken per cycle while the result queue has two free
//  slots; its events, if any, are registered in the queue and leave on
//  rsp_bus one per cycle while it is ready; with two-event samples the
//  sustained rate is set by the single-word output port of the result queue.
//  Synchronous reset clears registers, tracking state and the queue.
//  A stall on rsp_bus backs up through the queue into req_bus.ready.
// ----------------------------------------------------------------------------
module cymbal_zone_and_choke_detector_top #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   czc_req_if.sink                         req_bus,
   czc_rsp_if.source                       rsp_bus,
   input  logic                            csr_write_en,
   input  logic [czc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [czc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   czc_pkg::push_type push;
   logic              room;
   logic              accept;

   assign req_bus.ready = room;
   assign accept        = req_bus.valid && room;

   czc_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .accept          (accept),
      .zone_sample     (req_bus.zone_sample),
      .hit_velocity    (req_bus.hit_velocity),
      .reader_scanning (req_bus.reader_scanning),
      .now_ms          (req_bus.now_ms),
      .push            (push)
   );

   czc_evq u_evq (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

endmodule
